### design/eam_pkg.sv
// eam_pkg: shared widths, register indexes and reset values for the
// edge-aware moving average block; no dependencies
package eam_pkg;

  localparam int SAMPLE_W       = 8;
  localparam int RECLEN_W       = 15;
  localparam int SWIDTH_W       = 5;
  localparam int CFG_DATA_W     = 15;
  localparam int CFG_IDX_W      = 1;

  localparam int MAX_WIDTH_DEF  = 16;
  localparam int MAX_RECORD_DEF = 16384;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WIDTH = 1'd1;

  localparam logic [RECLEN_W-1:0] RECLEN_RESET = 15'd1024;
  localparam logic [SWIDTH_W-1:0] SWIDTH_RESET = 5'd1;

endpackage

### design/eam_in_if.sv
// eam_in_if: sample input channel, valid/ready handshake
// depends on eam_pkg
interface eam_in_if;
  import eam_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### design/eam_out_if.sv
// eam_out_if: smoothed result channel, valid/ready handshake
// depends on eam_pkg
interface eam_out_if;
  import eam_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] smoothed;
  logic                last_of_run;
  logic                end_of_record;

  modport source (output valid, output smoothed, output last_of_run, output end_of_record,
                  input ready);
  modport sink (input valid, input smoothed, input last_of_run, input end_of_record,
                output ready);
endinterface

### design/eam_window_mem.sv
// eam_window_mem: sample window store, one write and one read port,
// read data registered; depends on eam_pkg
module eam_window_mem #(
  parameter int DEPTH  = eam_pkg::MAX_WIDTH_DEF + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [eam_pkg::SAMPLE_W-1:0] wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [eam_pkg::SAMPLE_W-1:0] rdata
);
  import eam_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/eam_divider.sv
// eam_divider: restoring divider, one quotient bit per cycle, for sums
// whose quotient fits a sample; depends on eam_pkg
module eam_divider #(
  parameter int CNT_W = 5,
  parameter int SUM_W = eam_pkg::SAMPLE_W + CNT_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         done,
  output logic [eam_pkg::SAMPLE_W-1:0] quotient
);
  import eam_pkg::*;

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    dsh;
  logic [STEP_W-1:0]   step;
  logic                busy;
  logic                ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsh  <= SUM_W'(divisor) << (SAMPLE_W - 1);
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quotient <= {quotient[SAMPLE_W-2:0], ge};
        dsh      <= dsh >> 1;
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/edge_aware_moving_average.sv
// Edge-aware centered moving average over a record of 8-bit samples.
// Channels: samples (sink) takes one raw sample per transfer; results
// (source) gives smoothed samples with last_of_run and end_of_record.
// Configuration: cfg_we/cfg_index/cfg_data write record_length (index 0)
// or smoothing_width (index 1); write only while the block is idle.
// Each sample is written into the window memory; the outputs it releases
// are then computed one at a time: the 2m+1 window terms (m up to
// width/2) plus an optional extra term are read from the memory one per
// cycle, summed, and divided by the term count in the divider.
// samples.ready is high only between items. The result register lets a
// result wait while the block returns for the next sample; a stalled
// receiver holds the next result in the divider until it is taken.
// Reset (rst, synchronous) restores record_length 1024 and width 1 and
// starts a new record; the window memory is not cleared.
module edge_aware_moving_average #(
  parameter int MAX_WIDTH  = eam_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RECORD = eam_pkg::MAX_RECORD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [eam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eam_pkg::CFG_DATA_W-1:0] cfg_data,
  eam_in_if.sink                         samples,
  eam_out_if.source                      results
);
  import eam_pkg::*;

  localparam int DEPTH  = MAX_WIDTH + 1;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_RECORD);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HALF_W = $clog2(MAX_WIDTH / 2 + 1);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 3);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int CMP_W  = (IDX_W + 1 > HALF_W) ? IDX_W + 1 : HALF_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SETUP, S_READ, S_DRAIN, S_DIV_GO, S_DIV_WAIT, S_PUSH
  } state_t;

  state_t              state;

  logic [RECLEN_W-1:0] record_length;
  logic [SWIDTH_W-1:0] smoothing_width;

  logic [IDX_W-1:0]    sample_index;
  logic [IDX_W-1:0]    emit_index;
  logic [SLOT_W-1:0]   wslot;

  logic [IDX_W-1:0]    i_cur;
  logic [SLOT_W-1:0]   slot_cur;
  logic                final_r;
  logic [IDX_W:0]      stop_r;
  logic [HALF_W-1:0]   half_r;
  logic                odd_r;

  logic [SLOT_W-1:0]   k;
  logic [HALF_W:0]     n_left;
  logic [SLOT_W-1:0]   extra_k;
  logic                extra_pend;
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    sum;
  logic                rd_pend;

  logic                out_valid;
  logic [SAMPLE_W-1:0] out_smoothed;
  logic                out_last;
  logic                out_eor;

  logic [IDX_W:0]      len_eff;
  logic [WID_W-1:0]    w_eff;
  logic [HALF_W-1:0]   half_c;
  logic                odd_c;
  logic [IDX_W:0]      idx_plus1;
  logic                fin_c;
  logic [IDX_W:0]      stop_c;

  logic [IDX_W-1:0]    dj;
  logic [CMP_W-1:0]    m_c;
  logic [HALF_W-1:0]   m_sel;
  logic                extra_c;

  logic                accept;
  logic                emit_more;
  logic                push_ok;
  logic                last_c;
  logic                do_finish;

  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;

  // effective record length and width after saturation
  always_comb begin
    if (record_length == '0) begin
      len_eff = (IDX_W + 1)'(1);
    end else if (32'(record_length) > 32'(MAX_RECORD)) begin
      len_eff = (IDX_W + 1)'(MAX_RECORD);
    end else begin
      len_eff = (IDX_W + 1)'(record_length);
    end
    if (32'(smoothing_width) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(smoothing_width);
    end
  end

  assign half_c    = HALF_W'(w_eff >> 1);
  assign odd_c     = w_eff[0] && (half_c != '0);
  assign idx_plus1 = {1'b0, sample_index} + (IDX_W + 1)'(1);
  assign fin_c     = (idx_plus1 >= len_eff);

  // index one past the last output this sample releases
  always_comb begin
    if (fin_c) begin
      stop_c = idx_plus1;
    end else if (CMP_W'(sample_index) >= CMP_W'(half_c)) begin
      stop_c = (IDX_W + 1)'(CMP_W'(idx_plus1) - CMP_W'(half_c));
    end else begin
      stop_c = '0;
    end
  end

  // symmetric pair count limited by both record edges
  assign dj = i_cur - emit_index;
  always_comb begin
    m_c = CMP_W'(half_r);
    if (CMP_W'(emit_index) < m_c) begin
      m_c = CMP_W'(emit_index);
    end
    if (CMP_W'(dj) < m_c) begin
      m_c = CMP_W'(dj);
    end
  end
  assign m_sel   = HALF_W'(m_c);
  assign extra_c = odd_r && (CMP_W'(half_r) <= CMP_W'(dj));

  // window slot of the sample k places before the current one
  always_comb begin
    if (k > slot_cur) begin
      rd_addr = SLOT_W'({1'b0, slot_cur} + (SLOT_W + 1)'(DEPTH) - {1'b0, k});
    end else begin
      rd_addr = slot_cur - k;
    end
  end

  assign accept    = samples.valid && samples.ready;
  assign emit_more = ({1'b0, emit_index} < stop_r);
  assign push_ok   = !out_valid || results.ready;
  assign last_c    = (({1'b0, emit_index} + (IDX_W + 1)'(1)) == stop_r);
  assign do_finish = (state == S_CHECK && !emit_more) ||
                     (state == S_PUSH && push_ok && last_c);
  assign rd_en     = (state == S_READ);
  assign div_start = (state == S_DIV_GO);

  assign samples.ready         = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.smoothed      = out_smoothed;
  assign results.last_of_run   = out_last;
  assign results.end_of_record = out_eor;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length   <= RECLEN_RESET;
      smoothing_width <= SWIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECORD_LENGTH:   record_length   <= cfg_data[RECLEN_W-1:0];
        REG_SMOOTHING_WIDTH: smoothing_width <= cfg_data[SWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_index <= '0;
      emit_index   <= '0;
      wslot        <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (state == S_PUSH && push_ok) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_SETUP) begin
        sum <= '0;
      end else if (rd_pend) begin
        sum <= sum + SUM_W'(rd_data);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            i_cur    <= sample_index;
            slot_cur <= wslot;
            final_r  <= fin_c;
            stop_r   <= stop_c;
            half_r   <= half_c;
            odd_r    <= odd_c;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= emit_more ? S_SETUP : S_IDLE;
        end
        S_SETUP: begin
          k          <= SLOT_W'(dj) + SLOT_W'(m_sel);
          n_left     <= {m_sel, 1'b0};
          extra_k    <= SLOT_W'(dj) - SLOT_W'(half_r);
          extra_pend <= extra_c;
          count      <= CNT_W'({m_sel, 1'b0}) + CNT_W'(1) + CNT_W'(extra_c);
          state      <= S_READ;
        end
        S_READ: begin
          if (n_left != '0) begin
            k      <= k - SLOT_W'(1);
            n_left <= n_left - (HALF_W + 1)'(1);
          end else if (extra_pend) begin
            k          <= extra_k;
            extra_pend <= 1'b0;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            out_smoothed <= div_quot;
            out_last     <= last_c;
            out_eor      <= final_r && (emit_index == i_cur);
            // the final output of a record restarts the emit count
            emit_index   <= (last_c && final_r) ? '0 : emit_index + IDX_W'(1);
            state        <= last_c ? S_IDLE : S_SETUP;
          end
        end
        default: state <= S_IDLE;
      endcase

      // record bookkeeping once all outputs of the sample are out
      if (do_finish) begin
        if (final_r) begin
          sample_index <= '0;
          wslot        <= '0;
        end else begin
          sample_index <= i_cur + IDX_W'(1);
          wslot        <= (slot_cur == SLOT_W'(DEPTH - 1)) ? '0 : slot_cur + SLOT_W'(1);
        end
      end
    end
  end

  eam_window_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (wslot),
    .wdata (samples.sample),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  eam_divider #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

`ifndef SYNTHESIS
  a_setup_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_SETUP |-> ({1'b0, emit_index} < stop_r))
    else $error("output setup with no pending output");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_eor_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eor |-> out_last)
    else $error("end of record on a result that is not last of run");

  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !rd_pend)
    else $error("window read still in flight while taking a sample");

  a_finish_next_idle: assert property (@(posedge clk) disable iff (rst)
    do_finish |=> state == S_IDLE)
    else $error("sample finished but sequencer not back to idle");
`endif

endmodule

### verif/tb.sv
// tb: self-checking bench for edge_aware_moving_average, one record-smoothing
// predictor checked against every result transfer; needs eam_pkg, eam_in_if, eam_out_if
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eam_pkg::*;

  localparam int WIN_DEPTH    = MAX_WIDTH_DEF + 1;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_of_run;
    logic                end_of_record;
  } result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  eam_in_if  samples ();
  eam_out_if results ();

  edge_aware_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block's registers and window memory
  logic [RECLEN_W-1:0] rec_len;
  logic [SWIDTH_W-1:0] smooth_width;
  logic [SAMPLE_W-1:0] window_mem [WIN_DEPTH];
  int unsigned         sample_idx;
  int unsigned         emit_idx;

  result_t             expected_smoothed [$];
  logic [SAMPLE_W-1:0] raw_samples [$];
  int unsigned         pushed_count = 0;
  int unsigned         accepted_count = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  logic                sample_taken = 1'b0;

  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  rx_mode_e    rx_mode = RX_OPEN;
  logic [7:0]  rx_mask = 8'hFF;
  int unsigned rx_left = 0;

  function automatic int unsigned record_span();
    int unsigned n;
    n = 32'(rec_len);
    if (n == 0) n = 1;
    if (n > MAX_RECORD_DEF) n = MAX_RECORD_DEF;
    return n;
  endfunction

  function automatic int unsigned window_width();
    return (32'(smooth_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : 32'(smooth_width);
  endfunction

  // mean of output j; top is the highest index inside the record so far
  function automatic logic [SAMPLE_W-1:0] window_mean(int unsigned j, int unsigned top,
                                                      int unsigned w);
    int unsigned half, sum, count;
    if (w < 2) return window_mem[j % WIN_DEPTH];
    half  = w / 2;
    sum   = 32'(window_mem[j % WIN_DEPTH]);
    count = 1;
    for (int unsigned d = 1; d <= half; d++) begin
      if (d <= j && j + d <= top) begin
        sum = sum + 32'(window_mem[(j - d) % WIN_DEPTH]) +
              32'(window_mem[(j + d) % WIN_DEPTH]);
        count += 2;
      end
    end
    // odd width adds the far right neighbor as an extra term
    if ((w % 2) != 0 && j + half <= top) begin
      sum = sum + 32'(window_mem[(j + half) % WIN_DEPTH]);
      count++;
    end
    return SAMPLE_W'(sum / count);
  endfunction

  task automatic advance_record(input logic [SAMPLE_W-1:0] value);
    int unsigned i, w, half, stop;
    bit          is_last;
    result_t     r;
    i       = sample_idx;
    w       = window_width();
    half    = (w < 2) ? 0 : w / 2;
    is_last = (i + 1 >= record_span());
    window_mem[i % WIN_DEPTH] = value;
    if (is_last) stop = i + 1;
    else stop = (i >= half) ? i - half + 1 : 0;
    for (int unsigned j = emit_idx; j < stop; j++) begin
      r.smoothed      = window_mean(j, i, w);
      r.last_of_run   = (j + 1 == stop);
      r.end_of_record = is_last && (j == i);
      expected_smoothed.push_back(r);
    end
    if (stop > emit_idx) emit_idx = stop;
    if (is_last) begin
      sample_idx = 0;
      emit_idx   = 0;
    end else begin
      sample_idx = (i + 1) & 32'h3FFF;
    end
  endtask

  // monitor: config tracking, result checks and sample transfers
  always @(posedge clk) begin : monitor
    result_t got, want;
    cycle_count++;
    if (rst) begin
      rec_len      = RECLEN_RESET;
      smooth_width = SWIDTH_RESET;
      sample_idx   = 0;
      emit_idx     = 0;
      for (int k = 0; k < WIN_DEPTH; k++) window_mem[k] = '0;
      sample_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RECORD_LENGTH) rec_len = cfg_data[RECLEN_W-1:0];
        else if (cfg_index == REG_SMOOTHING_WIDTH) smooth_width = cfg_data[SWIDTH_W-1:0];
      end
      if (results.valid && results.ready) begin
        got = {results.smoothed, results.last_of_run, results.end_of_record};
        if (expected_smoothed.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %0d/%0b/%0b", $time,
                   got.smoothed, got.last_of_run, got.end_of_record);
          mismatches++;
        end else begin
          want = expected_smoothed.pop_front();
          if (got.smoothed !== want.smoothed) begin
            $display("%0t ns: smoothed expected %0d, actual %0d", $time,
                     want.smoothed, got.smoothed);
            mismatches++;
          end
          if (got.last_of_run !== want.last_of_run) begin
            $display("%0t ns: last_of_run expected %0b, actual %0b", $time,
                     want.last_of_run, got.last_of_run);
            mismatches++;
          end
          if (got.end_of_record !== want.end_of_record) begin
            $display("%0t ns: end_of_record expected %0b, actual %0b", $time,
                     want.end_of_record, got.end_of_record);
            mismatches++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        advance_record(samples.sample);
        accepted_count++;
      end
      sample_taken <= samples.valid && samples.ready;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL edge_aware_moving_average");
      $finish;
    end
  end

  // driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin : driver
    logic                next_valid;
    logic [SAMPLE_W-1:0] next_sample;
    next_valid  = samples.valid;
    next_sample = samples.sample;
    if (rst) begin
      next_valid  = 1'b0;
      next_sample = '0;
    end else if (!samples.valid || sample_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (raw_samples.size() > 0) begin
        next_sample = raw_samples.pop_front();
        next_valid  = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    samples.valid  <= next_valid;
    samples.sample <= next_sample;
  end

  // receiver: stall pattern switches among four random modes
  always @(negedge clk) begin : receiver
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mask = 8'($urandom_range(0, 255));
      rx_left = $urandom_range(8, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   results.ready <= 1'b1;
      RX_COIN:   results.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: results.ready <= ($urandom_range(0, 3) == 0);
      default:   results.ready <= rx_mask[3'(rx_left % 8)];
    endcase
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    raw_samples.push_back(value);
    pushed_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != pushed_count || expected_smoothed.size() != 0);
    // a sample that releases nothing may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input bit set_len, input int unsigned len,
                              input bit set_width, input int unsigned width);
    if (set_len) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_RECORD_LENGTH;
      cfg_data  <= CFG_DATA_W'(len);
    end
    if (set_width) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_SMOOTHING_WIDTH;
      cfg_data  <= CFG_DATA_W'(width);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] raw_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent, len, width, remaining, count, pick;
    bit          set_len, set_width;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings pass samples through; then cut the record short
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'h55);
    push_sample(8'hAA);
    wait_idle();
    write_config(1, 2, 0, 0);
    push_sample(8'h3C);
    wait_idle();

    // zero length acts as one, zero width passes through
    write_config(1, 0, 1, 0);
    push_sample(8'hFF);
    push_sample(8'h01);
    wait_idle();

    // odd width with its repeated right neighbor
    write_config(1, 5, 1, 3);
    push_sample(8'hFF);
    push_sample(8'hFF);
    push_sample(8'h00);
    push_sample(8'hFF);
    push_sample(8'h00);
    wait_idle();

    // both registers beyond their limits, then narrow and cut mid-record
    write_config(1, 32767, 1, 31);
    repeat (10) push_sample(raw_level());
    wait_idle();
    write_config(0, 0, 1, 2);
    push_sample(raw_level());
    push_sample(raw_level());
    wait_idle();
    write_config(1, 1, 0, 0);
    push_sample(raw_level());
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 1;
        2:       len = $urandom_range(MAX_RECORD_DEF, 32767);
        3:       len = $urandom_range(25, 60);
        default: len = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 7))
        0:       width = MAX_WIDTH_DEF;
        1:       width = $urandom_range(17, 31);
        2:       width = $urandom_range(0, 1);
        default: width = $urandom_range(2, 15);
      endcase
      pick      = $urandom_range(0, 5);
      set_len   = (pick != 0);
      set_width = (pick != 1);
      write_config(set_len, len, set_width, width);
      remaining = (sample_idx + 1 >= record_span()) ? 1 : record_span() - sample_idx;
      // mostly whole records; sometimes stop partway to change settings mid-record
      if (remaining <= 60 && $urandom_range(0, 3) != 0) count = remaining;
      else count = $urandom_range(1, (remaining < 20) ? remaining : 20);
      repeat (count) push_sample(raw_level());
      sent += count;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS edge_aware_moving_average");
    end else begin
      $display("FAIL edge_aware_moving_average");
    end
    $finish;
  end

endmodule

### sim.f
design/eam_pkg.sv
design/eam_in_if.sv
design/eam_out_if.sv
design/eam_window_mem.sv
design/eam_divider.sv
design/edge_aware_moving_average.sv
verif/tb.sv
